/* rtl/melody_note_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// Melody note sequencer assertion macros
// Shared property wrappers for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef MELODY_NOTE_SEQUENCER_CORE_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MNS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MNS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mns_pkg.sv */
// ----------------------------------------------------------------------------
// Melody note sequencer package
// Command codes, widths and shared types of the sequencer.
// ----------------------------------------------------------------------------
package mns_pkg;

	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned DUR_W   = 10;   // longest note is 520 ms
	localparam int unsigned GAP_W   = 10;
	localparam int unsigned REM_W   = 16;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned SEL_W   = 3;
	localparam int unsigned STEP_W  = DUR_W + 1;   // note plus gap, at most 1543 ms

	localparam logic [SEL_W-1:0] NUM_TUNES     = 3'd5;
	localparam logic [GAP_W-1:0] GAP_RESET     = 10'd20;
	localparam logic [POS_W-1:0] MAX_TUNE_LEN  = 4'd13;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_PLAY = 2'd1,
		FUNC_STOP = 2'd2,
		FUNC_BEEP = 2'd3
	} func_t;

	// One note read from the melody table.
	typedef struct packed {
		logic              in_range;   // position lies inside the melody
		logic [FREQ_W-1:0] freq;       // zero for a rest
		logic [DUR_W-1:0]  dur;
	} note_t;

endpackage

/* rtl/mns_note_rom.sv */
// ----------------------------------------------------------------------------
// Melody note table
// Read-only table of the five melodies; returns one note and a range flag.
// ----------------------------------------------------------------------------
module mns_note_rom (
	input  logic [mns_pkg::SEL_W-1:0] sel,
	input  logic [mns_pkg::POS_W-1:0] pos,
	output mns_pkg::note_t            note
);

	logic [mns_pkg::POS_W-1:0]  tune_len;
	logic [mns_pkg::FREQ_W-1:0] freq;
	logic [mns_pkg::DUR_W-1:0]  dur;

	always_comb begin
		unique case (sel)
			3'd0:    tune_len = 4'd4;
			3'd1:    tune_len = 4'd5;
			3'd2:    tune_len = 4'd8;
			3'd3:    tune_len = 4'd4;
			3'd4:    tune_len = 4'd13;
			default: tune_len = 4'd0;
		endcase
	end

	always_comb begin
		freq = '0;
		dur  = '0;
		unique case ({sel, pos})
			// success
			{3'd0, 4'd0}:  begin freq = 16'd523;  dur = 10'd120; end
			{3'd0, 4'd1}:  begin freq = 16'd659;  dur = 10'd120; end
			{3'd0, 4'd2}:  begin freq = 16'd784;  dur = 10'd160; end
			{3'd0, 4'd3}:  begin freq = 16'd1047; dur = 10'd260; end
			// alert
			{3'd1, 4'd0}:  begin freq = 16'd988;  dur = 10'd100; end
			{3'd1, 4'd1}:  begin freq = 16'd0;    dur = 10'd70;  end
			{3'd1, 4'd2}:  begin freq = 16'd988;  dur = 10'd100; end
			{3'd1, 4'd3}:  begin freq = 16'd0;    dur = 10'd70;  end
			{3'd1, 4'd4}:  begin freq = 16'd784;  dur = 10'd240; end
			// scale
			{3'd2, 4'd0}:  begin freq = 16'd262;  dur = 10'd110; end
			{3'd2, 4'd1}:  begin freq = 16'd294;  dur = 10'd110; end
			{3'd2, 4'd2}:  begin freq = 16'd330;  dur = 10'd110; end
			{3'd2, 4'd3}:  begin freq = 16'd349;  dur = 10'd110; end
			{3'd2, 4'd4}:  begin freq = 16'd392;  dur = 10'd110; end
			{3'd2, 4'd5}:  begin freq = 16'd440;  dur = 10'd110; end
			{3'd2, 4'd6}:  begin freq = 16'd494;  dur = 10'd110; end
			{3'd2, 4'd7}:  begin freq = 16'd523;  dur = 10'd220; end
			// startup
			{3'd3, 4'd0}:  begin freq = 16'd392;  dur = 10'd100; end
			{3'd3, 4'd1}:  begin freq = 16'd523;  dur = 10'd100; end
			{3'd3, 4'd2}:  begin freq = 16'd659;  dur = 10'd120; end
			{3'd3, 4'd3}:  begin freq = 16'd784;  dur = 10'd220; end
			// birthday
			{3'd4, 4'd0}:  begin freq = 16'd392;  dur = 10'd170; end
			{3'd4, 4'd1}:  begin freq = 16'd392;  dur = 10'd170; end
			{3'd4, 4'd2}:  begin freq = 16'd440;  dur = 10'd340; end
			{3'd4, 4'd3}:  begin freq = 16'd392;  dur = 10'd340; end
			{3'd4, 4'd4}:  begin freq = 16'd523;  dur = 10'd340; end
			{3'd4, 4'd5}:  begin freq = 16'd494;  dur = 10'd520; end
			{3'd4, 4'd6}:  begin freq = 16'd0;    dur = 10'd120; end
			{3'd4, 4'd7}:  begin freq = 16'd392;  dur = 10'd170; end
			{3'd4, 4'd8}:  begin freq = 16'd392;  dur = 10'd170; end
			{3'd4, 4'd9}:  begin freq = 16'd440;  dur = 10'd340; end
			{3'd4, 4'd10}: begin freq = 16'd392;  dur = 10'd340; end
			{3'd4, 4'd11}: begin freq = 16'd587;  dur = 10'd340; end
			{3'd4, 4'd12}: begin freq = 16'd523;  dur = 10'd520; end
			default:       begin freq = '0;       dur = '0;      end
		endcase
	end

	assign note.in_range = (pos < tune_len);
	assign note.freq     = freq;
	assign note.dur      = dur;

endmodule

/* rtl/melody_note_sequencer_core.sv */
// Path: an accepted item passes the input register, then the result register,
//   where out_valid marks it; the result transfers out while out_stall is low.
// Throughput: one item per cycle while out_stall is low, from a single next-state
//   pass; a stalled result lets the input register take one more item, then in_stall holds the sender.
// Reset: arst_n clears both valid bits, all sequencer state and sets the note
//   gap to 20 ms; payload registers are not reset.
// ----------------------------------------------------------------------------
// Melody note sequencer core
// Buzzer melody player driven by millisecond ticks, play, stop and beep items.
// ----------------------------------------------------------------------------
`include "melody_note_sequencer_core_defines.svh"

module melody_note_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: note gap in ms
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [2:0]  melody_id,
	input  logic [15:0] beep_frequency,
	input  logic [15:0] beep_duration_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] tone_frequency,
	output logic        playing,
	output logic [3:0]  note_index,
	output logic        accepted
);

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	logic [mns_pkg::GAP_W-1:0]  gap_q;
	logic [mns_pkg::FREQ_W-1:0] freq_q,    freq_n;
	logic [mns_pkg::REM_W-1:0]  rem_q,     rem_n;
	logic [mns_pkg::SEL_W-1:0]  sel_q,     sel_n;
	logic [mns_pkg::POS_W-1:0]  pos_q,     pos_n;
	logic [mns_pkg::STEP_W-1:0] elapsed_q, elapsed_n;
	logic [mns_pkg::STEP_W-1:0] total_q,   total_n;
	logic                       play_q,    play_n;
	logic                       ok_n;

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic                        valid_s1;
	mns_pkg::func_t              func_s1;
	logic [mns_pkg::SEL_W-1:0]   id_s1;
	logic [mns_pkg::FREQ_W-1:0]  bfreq_s1;
	logic [mns_pkg::REM_W-1:0]   bdur_s1;

	logic advance;
	logic in_xfer;

	// The result register is free when empty or being drained this cycle.
	assign advance  = ~out_valid | ~out_stall;
	// Hold the input side only while the stage-1 item cannot move on.
	assign in_stall = valid_s1 & ~advance;
	assign in_xfer  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1  <= mns_pkg::func_t'(func);
			id_s1    <= melody_id;
			bfreq_s1 <= beep_frequency;
			bdur_s1  <= beep_duration_ms;
		end
	end

	// ------------------------------------------------------------------
	// Note lookup: note 0 of the requested melody on play, else the note
	// after the current one for a tick that closes a step.
	// ------------------------------------------------------------------
	logic [mns_pkg::SEL_W-1:0] rom_sel;
	logic [mns_pkg::POS_W-1:0] rom_pos;
	logic [mns_pkg::POS_W-1:0] pos_inc;
	mns_pkg::note_t            rom_note;

	assign pos_inc = pos_q + 1'b1;
	assign rom_sel = (func_s1 == mns_pkg::FUNC_PLAY) ? id_s1 : sel_q;
	assign rom_pos = (func_s1 == mns_pkg::FUNC_PLAY) ? '0 : pos_inc;

	mns_note_rom u_note_rom (
		.sel  (rom_sel),
		.pos  (rom_pos),
		.note (rom_note)
	);

	// Tone and step length of the looked-up note; a rest keeps the buzzer quiet.
	logic                       note_sounds;
	logic [mns_pkg::STEP_W-1:0] note_total;
	logic [mns_pkg::STEP_W-1:0] elapsed_inc;

	assign note_sounds = (rom_note.freq != '0) && (rom_note.dur != '0);
	assign note_total  = {1'b0, rom_note.dur} + {1'b0, gap_q};
	assign elapsed_inc = elapsed_q + 1'b1;

	// ------------------------------------------------------------------
	// Next-state pass for the stage-1 item
	// ------------------------------------------------------------------
	always_comb begin
		freq_n    = freq_q;
		rem_n     = rem_q;
		sel_n     = sel_q;
		pos_n     = pos_q;
		elapsed_n = elapsed_q;
		total_n   = total_q;
		play_n    = play_q;
		ok_n      = 1'b1;

		unique case (func_s1)
			mns_pkg::FUNC_TICK: begin
				// Count the tone down and silence it when time runs out.
				if (rem_q != '0) begin
					rem_n = rem_q - 1'b1;
					if (rem_q == 16'd1) begin
						freq_n = '0;
					end
				end
				if (play_q) begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= total_q) begin
						if (!rom_note.in_range) begin
							// Last note done: drop the melody.
							freq_n    = '0;
							rem_n     = '0;
							sel_n     = '0;
							pos_n     = '0;
							elapsed_n = '0;
							total_n   = '0;
							play_n    = 1'b0;
						end else begin
							pos_n     = pos_inc;
							freq_n    = note_sounds ? rom_note.freq : '0;
							rem_n     = note_sounds ? {6'd0, rom_note.dur} : '0;
							elapsed_n = '0;
							total_n   = note_total;
						end
					end
				end
			end
			mns_pkg::FUNC_PLAY: begin
				if (id_s1 < mns_pkg::NUM_TUNES) begin
					// Restart from note 0, dropping whatever was playing.
					sel_n     = id_s1;
					pos_n     = '0;
					play_n    = 1'b1;
					freq_n    = note_sounds ? rom_note.freq : '0;
					rem_n     = note_sounds ? {6'd0, rom_note.dur} : '0;
					elapsed_n = '0;
					total_n   = note_total;
				end else begin
					ok_n = 1'b0;
				end
			end
			mns_pkg::FUNC_STOP: begin
				freq_n    = '0;
				rem_n     = '0;
				sel_n     = '0;
				pos_n     = '0;
				elapsed_n = '0;
				total_n   = '0;
				play_n    = 1'b0;
			end
			mns_pkg::FUNC_BEEP: begin
				// Stop the melody; sound the tone only if both fields are nonzero.
				sel_n     = '0;
				pos_n     = '0;
				elapsed_n = '0;
				total_n   = '0;
				play_n    = 1'b0;
				if ((bfreq_s1 != '0) && (bdur_s1 != '0)) begin
					freq_n = bfreq_s1;
					rem_n  = bdur_s1;
				end else begin
					freq_n = '0;
					rem_n  = '0;
				end
			end
			default: begin
				ok_n = 1'b1;
			end
		endcase
	end

	logic step_en;
	assign step_en = valid_s1 & advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q     <= mns_pkg::GAP_RESET;
			freq_q    <= '0;
			rem_q     <= '0;
			sel_q     <= '0;
			pos_q     <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
			play_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				gap_q <= cfg_wdata;
			end
			if (step_en) begin
				freq_q    <= freq_n;
				rem_q     <= rem_n;
				sel_q     <= sel_n;
				pos_q     <= pos_n;
				elapsed_q <= elapsed_n;
				total_q   <= total_n;
				play_q    <= play_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			tone_frequency <= freq_n;
			playing        <= play_n;
			note_index     <= pos_n;
			accepted       <= ok_n;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MNS_ASSERT(a_tone_needs_time, (freq_q != '0) |-> (rem_q != '0), "tone on with no time left")
	`MNS_ASSERT(a_idle_clear, !play_q |-> ((pos_q == '0) && (elapsed_q == '0) && (total_q == '0)), "melody state left over while idle")
	`MNS_ASSERT(a_pos_range, play_q |-> (pos_q < mns_pkg::MAX_TUNE_LEN), "note position past longest melody")
	`MNS_ASSERT(a_result_held, (out_valid && out_stall) |=> out_valid, "stalled result dropped")
	`MNS_ASSERT_ALWAYS(a_s1_held, (arst_n && valid_s1 && !advance) |=> (!arst_n || valid_s1), "stage-1 item lost while held")

endmodule
